>>> rtl/xcfr_pkg.sv
package xcfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 8;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_START_BYTE     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MIN_HEADER_LEN = cfg_idx_t'(1);

  localparam byte_t START_BYTE_RST     = byte_t'(0);
  localparam byte_t MIN_HEADER_LEN_RST = byte_t'(1);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

endpackage

>>> rtl/xcfr_if.sv
interface xcfr_byte_if;
  import xcfr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfr_result_if;
  import xcfr_pkg::*;
  logic  valid;
  logic  ready;
  logic  payload_valid;
  byte_t payload_byte;
  byte_t payload_index;
  logic  frame_end;
  logic  frame_ok;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_end, output frame_ok,
                  input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_index, input frame_end, input frame_ok,
                output ready);
endinterface

interface xcfr_cfg_if;
  import xcfr_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/xor_checked_frame_receiver.sv
// An accepted byte's result item is in the output register from the next cycle.
// Throughput: one byte per cycle; the frame state and the output register both
// advance per accepted item; with a result held, a byte is taken only as it leaves.
// Reset (rst, synchronous, active high): hunt for start byte, counters and check
// cleared, output register empty, start_byte = 0, min_header_len = 1.
module xor_checked_frame_receiver (
  input logic          clk,
  input logic          rst,
  xcfr_byte_if.sink    rx,
  xcfr_result_if.source res,
  xcfr_cfg_if.sink     cfg
);
  import xcfr_pkg::*;

  // Configuration registers; writes land at any time and apply from the next byte.
  byte_t start_byte;
  byte_t min_header_len;

  // Frame state
  phase_t phase, phase_next;
  byte_t  frame_length, frame_length_next;
  byte_t  byte_count, byte_count_next;
  byte_t  running_check, running_check_next;

  // Output register
  logic  out_valid;
  logic  payload_valid, payload_valid_next;
  byte_t payload_byte, payload_byte_next;
  byte_t payload_index, payload_index_next;
  logic  frame_end, frame_end_next;
  logic  frame_ok, frame_ok_next;

  logic  rx_take;
  byte_t count_inc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RST;
      min_header_len <= MIN_HEADER_LEN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_BYTE:     start_byte     <= cfg.data;
        REG_MIN_HEADER_LEN: min_header_len <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Take a new byte when the output register is empty or being emptied.
  assign rx.ready = !out_valid || res.ready;
  assign rx_take  = rx.valid && rx.ready;

  assign count_inc = byte_count + byte_t'(1);

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    byte_count_next    = byte_count;
    running_check_next = running_check;
    payload_valid_next = 1'b0;
    payload_byte_next  = '0;
    payload_index_next = '0;
    frame_end_next     = 1'b0;
    frame_ok_next      = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (rx.rx_byte == start_byte) phase_next = PH_LEN;
      end
      PH_LEN: begin
        // A short length abandons the frame; it is not rechecked as a start byte.
        if (rx.rx_byte <= min_header_len) begin
          phase_next = PH_HUNT;
        end else begin
          frame_length_next  = rx.rx_byte;
          byte_count_next    = '0;
          running_check_next = rx.rx_byte;
          phase_next         = PH_BODY;
        end
      end
      PH_BODY: begin
        // Stream each body byte out at once with its position.
        payload_valid_next = 1'b1;
        payload_byte_next  = rx.rx_byte;
        payload_index_next = byte_count;
        running_check_next = running_check ^ rx.rx_byte;
        byte_count_next    = count_inc;
        if (count_inc >= frame_length) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        frame_end_next  = 1'b1;
        frame_ok_next   = (rx.rx_byte == running_check);
        phase_next      = PH_HUNT;
        byte_count_next = '0;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= '0;
      byte_count    <= '0;
      running_check <= '0;
    end else if (rx_take) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      byte_count    <= byte_count_next;
      running_check <= running_check_next;
    end
  end

  // Every accepted byte yields exactly one result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      payload_valid <= payload_valid_next;
      payload_byte  <= payload_byte_next;
      payload_index <= payload_index_next;
      frame_end     <= frame_end_next;
      frame_ok      <= frame_ok_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.payload_valid = payload_valid;
  assign res.payload_byte  = payload_byte;
  assign res.payload_index = payload_index;
  assign res.frame_end     = frame_end;
  assign res.frame_ok      = frame_ok;

endmodule

>>> tb/xor_checked_frame_receiver_tb.sv
module xor_checked_frame_receiver_tb;
  import xcfr_pkg::*;

  // Index past the end of the register map; a write there must change nothing.
  localparam cfg_idx_t REG_UNMAPPED = cfg_idx_t'(2);

  // One result item as the receiver should report it.
  typedef struct packed {
    logic  payload_valid;
    byte_t payload_byte;
    byte_t payload_index;
    logic  frame_end;
    logic  frame_ok;
  } frame_out_t;

  logic clk;
  logic rst;

  xcfr_byte_if   rx_ch ();
  xcfr_result_if res_ch ();
  xcfr_cfg_if    cfg_ch ();

  xor_checked_frame_receiver dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Bytes still to be offered, and the results owed for bytes already taken.
  byte_t      byte_q[$];
  frame_out_t result_q[$];

  // Shadow copy of the deframer: registers and frame state.
  byte_t  start_cfg;
  byte_t  min_len_cfg;
  phase_t rx_phase;
  byte_t  body_len;
  byte_t  body_cnt;
  byte_t  xor_acc;

  // Handshake bookkeeping and idling knobs.
  logic rx_taken;
  int   src_gap;
  int   sink_hold;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_request;

  int fail_count;
  int bytes_in;
  int good_frames;
  int bad_frames;
  int body_bytes;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case the block wedges a handshake.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Gap length in cycles: mostly none, otherwise short, now and then long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Advance the shadow deframer by one received byte and return its result item.
  function automatic frame_out_t deframe_byte(byte_t b);
    frame_out_t o;
    o = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == start_cfg) rx_phase = PH_LEN;
      end
      PH_LEN: begin
        // A length not above the threshold abandons the frame; this byte is
        // never reconsidered as a start marker.
        if (b <= min_len_cfg) begin
          rx_phase = PH_HUNT;
        end else begin
          body_len = b;
          body_cnt = '0;
          xor_acc  = b;
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        o.payload_valid = 1'b1;
        o.payload_byte  = b;
        o.payload_index = body_cnt;
        xor_acc  = xor_acc ^ b;
        body_cnt = body_cnt + 8'd1;
        if (body_cnt >= body_len) rx_phase = PH_CHECK;
      end
      default: begin
        o.frame_end = 1'b1;
        o.frame_ok  = (b == xor_acc);
        rx_phase    = PH_HUNT;
        body_cnt    = '0;
      end
    endcase
    return o;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Source side: offer queued bytes, holding each until it is taken, with
  // random gaps between items.
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        rx_ch.valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= byte_q.pop_front();
        src_gap = pick_gap(src_idle_pct);
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: random back-pressure, plus one long hold-off on request so the
  // output register fills and the input stalls.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      sink_hold    = 299;
      res_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      res_ch.ready <= 1'b0;
    end else begin
      sink_hold = pick_gap(snk_idle_pct);
      res_ch.ready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  // Monitor: check each result against the oldest owed one, then predict the
  // result of any byte taken at this edge, then track register writes.
  always @(posedge clk) begin
    frame_out_t want;
    if (rst) begin
      rx_taken    <= 1'b0;
      start_cfg   = START_BYTE_RST;
      min_len_cfg = MIN_HEADER_LEN_RST;
      rx_phase    = PH_HUNT;
      body_len    = '0;
      body_cnt    = '0;
      xor_acc     = '0;
      result_q.delete();
    end else begin
      rx_taken <= rx_ch.valid && rx_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $error("result item with none expected");
        end else begin
          want = result_q.pop_front();
          check_field("payload_valid", want.payload_valid, res_ch.payload_valid);
          check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
          check_field("payload_index", want.payload_index, res_ch.payload_index);
          check_field("frame_end", want.frame_end, res_ch.frame_end);
          check_field("frame_ok", want.frame_ok, res_ch.frame_ok);
          if (want.payload_valid) body_bytes++;
          if (want.frame_end && want.frame_ok) good_frames++;
          if (want.frame_end && !want.frame_ok) bad_frames++;
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        result_q.push_back(deframe_byte(rx_ch.rx_byte));
        bytes_in++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_START_BYTE:     start_cfg   = cfg_ch.data;
          REG_MIN_HEADER_LEN: min_len_cfg = cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, byte_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every byte is taken and every result has come back,
  // then let the pipeline settle.
  task automatic wait_idle();
    while (byte_q.size() != 0 || rx_ch.valid || result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Queue one frame using the current start marker. Corrupt flips one bit of
  // the check byte; a nonzero cut drops that many trailing body bytes and the
  // check byte, so the next bytes land inside the broken frame.
  task automatic queue_frame(int len, bit corrupt, int cut);
    byte_t sum;
    byte_t b;
    sum = byte_t'(len);
    byte_q.push_back(start_cfg);
    byte_q.push_back(byte_t'(len));
    for (int i = 0; i < len - cut; i++) begin
      b   = byte_t'($urandom);
      sum = sum ^ b;
      byte_q.push_back(b);
    end
    if (cut == 0) begin
      if (corrupt) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      byte_q.push_back(sum);
    end
  endtask

  // Mostly well-formed frames with random bodies; the rest is line noise,
  // short-length headers, bad checks and truncated frames.
  task automatic queue_traffic(int n);
    int target;
    int pick;
    int len;
    target = byte_q.size() + n;
    while (byte_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) byte_q.push_back(byte_t'($urandom));
      end else if (pick < 20 || min_len_cfg == 8'hFF) begin
        byte_q.push_back(start_cfg);
        byte_q.push_back(byte_t'($urandom_range(0, int'(min_len_cfg))));
      end else begin
        len = int'(min_len_cfg) + 1;
        if ($urandom_range(0, 19) == 0) len += $urandom_range(0, 254 - int'(min_len_cfg));
        else len += $urandom_range(0, 6);
        if (len > 255) len = 255;
        queue_frame(len, pick < 30, (pick >= 30 && pick < 34) ? $urandom_range(1, len) : 0);
      end
    end
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_START_BYTE;
    cfg_ch.data   = '0;
    rst           = 1'b1;
    src_gap       = 0;
    sink_hold     = 0;
    src_idle_pct  = 20;
    snk_idle_pct  = 20;
    hold_request  = 1'b0;
    fail_count    = 0;
    bytes_in      = 0;
    good_frames   = 0;
    bad_frames    = 0;
    body_bytes    = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed stream under reset settings (start 0x00, threshold 1):
    // a short length equal to the start marker, which must not restart a frame;
    // a good frame with 0xFF/0x00 body; a bad check; noise; a length exactly at
    // the threshold; a three-byte good frame.
    byte_q = '{8'h00, 8'h00,
               8'h00, 8'h02, 8'hFF, 8'h00, 8'hFD,
               8'h00, 8'h02, 8'hAA, 8'h55, 8'hFC,
               8'hFF, 8'h80, 8'h7F,
               8'h00, 8'h01,
               8'h00, 8'h03, 8'h01, 8'h02, 8'h04, 8'h04};
    wait_idle();

    // Typical framing marker, small threshold.
    write_reg(REG_START_BYTE, 8'h7E);
    write_reg(REG_MIN_HEADER_LEN, 8'h02);
    queue_traffic(200);
    wait_idle();

    // All-ones marker, zero threshold (one-byte bodies allowed); no idling.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_MIN_HEADER_LEN, 8'h00);
    queue_traffic(200);
    wait_idle();

    // Highest usable threshold: only full 255-byte bodies get through.
    src_idle_pct = 10;
    snk_idle_pct = 30;
    write_reg(REG_START_BYTE, byte_t'($urandom));
    write_reg(REG_MIN_HEADER_LEN, 8'd254);
    queue_traffic(250);
    wait_idle();

    // Threshold at its maximum: every frame dies at its length byte.
    // Also poke an unmapped index, which must leave both registers alone.
    write_reg(REG_MIN_HEADER_LEN, 8'hFF);
    write_reg(REG_UNMAPPED, byte_t'($urandom));
    queue_traffic(40);
    wait_idle();

    // Zero marker again, with one long sink hold-off while bytes keep coming.
    src_idle_pct = 5;
    snk_idle_pct = 15;
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_MIN_HEADER_LEN, 8'd5);
    hold_request = 1'b1;
    queue_traffic(200);
    wait_idle();

    repeat (5) @(posedge clk);
    $display("Run covered %0d bytes: %0d good and %0d bad frames, %0d body bytes,",
             bytes_in, good_frames, bad_frames, body_bytes);
    $display("over six register settings, noise, truncation and a long output stall.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
